>>> rtl/sorted_list_insert_delete_defines.svh
// assertion macros for the sorted list block
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define SLI_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent checked at the same edge as the antecedent
`define SLI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked at the clock edge after the antecedent
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sli_pkg.sv
// shared constants, types and helpers for the sorted list block
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GRP_SIZE = 32;
    localparam int GRP_W    = 5;
    localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GSEL_W   = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
    localparam int POS_W    = GSEL_W + GRP_W;
    localparam int PAD_W    = NUM_GRP * GRP_SIZE;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_ENC1,
        ST_ENC2,
        ST_APPLY
    } sli_state_t;

    typedef struct packed {
        logic cmp_en;
        logic ins_sel;
        logic do_ins;
        logic do_del;
    } sli_ctl_t;

    // binary index of the set bit in a one-hot group
    function automatic logic [GRP_W-1:0] grp_encode(input logic [GRP_SIZE-1:0] onehot);
        logic [GRP_W-1:0] res;
        res = '0;
        for (int k = 0; k < GRP_SIZE; k++) begin
            if (onehot[k]) begin
                res = res | GRP_W'(k);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sli_cell.sv
// one storage cell of the sorted row: entry, compare flags and shift mux
`timescale 1ns / 1ps
`default_nettype none

module sli_cell (
    input  wire                          aclk,
    input  wire sli_pkg::sli_ctl_t       ctl,
    input  wire logic signed [31:0]      value,
    input  wire logic [sli_pkg::CNT_W-1:0] count,
    input  wire logic [sli_pkg::IDX_W-1:0] cell_idx,
    input  wire logic signed [31:0]      left_entry,
    input  wire logic                    left_flag,
    input  wire logic signed [31:0]      right_entry,
    output logic signed [31:0]           entry,
    output logic                         flag,
    output logic                         first,
    output logic                         eq
);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               flag_reg;
    logic               flag_next;
    logic               eq_reg;
    logic               eq_next;
    logic               occ;
    logic               cmp_hit;

    assign occ     = count > sli_pkg::CNT_W'(cell_idx);
    assign cmp_hit = ctl.ins_sel ? (entry_reg <= value) : (entry_reg < value);

    always_comb begin
        flag_next = !(occ && cmp_hit);
        eq_next   = occ && (entry_reg == value);
    end

    always_comb begin
        entry_next = entry_reg;
        if (ctl.do_ins) begin
            if (left_flag) begin
                entry_next = left_entry;
            end else if (flag_reg) begin
                entry_next = value;
            end
        end else if (ctl.do_del && flag_reg) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (ctl.cmp_en) begin
            flag_reg <= flag_next;
            eq_reg   <= eq_next;
        end
    end

    assign entry = entry_reg;
    assign flag  = flag_reg;
    assign first = flag_reg & ~left_flag;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

>>> rtl/sli_enc.sv
// two-stage registered encoder from the row's one-hot boundary to an index
`timescale 1ns / 1ps
`default_nettype none

module sli_enc (
    input  wire                            aclk,
    input  wire logic [sli_pkg::CAPACITY-1:0] first_vec,
    input  wire logic [sli_pkg::CAPACITY-1:0] eq_vec,
    output logic [sli_pkg::IDX_W-1:0]      pos,
    output logic                           found
);

    logic [sli_pkg::PAD_W-1:0]   first_pad;
    logic [sli_pkg::PAD_W-1:0]   eq_pad;
    logic [sli_pkg::NUM_GRP-1:0] grp_any_reg;
    logic [sli_pkg::NUM_GRP-1:0] grp_eq_reg;
    logic [sli_pkg::GRP_W-1:0]   grp_idx_reg [sli_pkg::NUM_GRP];
    logic [sli_pkg::POS_W-1:0]   pos_next;
    logic [sli_pkg::POS_W-1:0]   pos_reg;
    logic                        found_next;
    logic                        found_reg;
    logic [sli_pkg::GSEL_W-1:0]  hi;
    logic [sli_pkg::GRP_W-1:0]   lo;

    assign first_pad = sli_pkg::PAD_W'(first_vec);
    assign eq_pad    = sli_pkg::PAD_W'(eq_vec);

    // stage one: per group of cells
    always_ff @(posedge aclk) begin
        for (int g = 0; g < sli_pkg::NUM_GRP; g++) begin
            grp_any_reg[g] <= |first_pad[g*sli_pkg::GRP_SIZE +: sli_pkg::GRP_SIZE];
            grp_eq_reg[g]  <= |eq_pad[g*sli_pkg::GRP_SIZE +: sli_pkg::GRP_SIZE];
            grp_idx_reg[g] <= sli_pkg::grp_encode(
                first_pad[g*sli_pkg::GRP_SIZE +: sli_pkg::GRP_SIZE]);
        end
    end

    // stage two: across groups
    always_comb begin
        hi = '0;
        lo = '0;
        for (int g = 0; g < sli_pkg::NUM_GRP; g++) begin
            if (grp_any_reg[g]) begin
                hi = hi | sli_pkg::GSEL_W'(g);
                lo = lo | grp_idx_reg[g];
            end
        end
        pos_next   = {hi, lo};
        found_next = |grp_eq_reg;
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        found_reg <= found_next;
    end

    assign pos   = pos_reg[sli_pkg::IDX_W-1:0];
    assign found = found_reg;

endmodule

`default_nettype wire

>>> rtl/sorted_list_insert_delete.sv
// Sorted list of up to CAPACITY signed 32-bit values held in a row of cells, one
// entry per cell. A request is taken only in idle and then passes through a compare
// state in which every cell compares its entry with the value, the encoder states
// ENC1 and ENC2 of the registered encoder that turns the row's boundary into an
// index, and an update state in which the cells shift left or right by one and the
// result beat is registered; the next request is taken once the update is done.
// A new request is taken while a finished result still waits on m_ready; the
// update stalls only if the previous result has not been taken. No clearing
// pass runs after reset: the count alone marks which cells hold values.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_list_insert_delete_defines.svh"

module sorted_list_insert_delete (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_req_type,
    input  wire logic signed [31:0] s_value,
    output logic              m_valid,
    input  wire               m_ready,
    output logic [1:0]        m_status,
    output logic [9:0]        m_position,
    output logic [10:0]       m_entry_count,
    output logic              m_is_empty,
    output logic              m_is_full
);

    localparam int N = sli_pkg::CAPACITY;

    sli_pkg::sli_state_t state_reg;
    sli_pkg::sli_state_t state_next;
    sli_pkg::sli_ctl_t   ctl;

    logic [1:0]                req_reg;
    logic signed [31:0]        value_reg;
    logic [sli_pkg::CNT_W-1:0] count_reg;
    logic [sli_pkg::CNT_W-1:0] count_next;
    logic                      apply_go;
    logic                      list_full;

    logic signed [31:0] entry_w [N];
    logic [N-1:0]       flag_vec;
    logic [N-1:0]       first_vec;
    logic [N-1:0]       eq_vec;

    logic [sli_pkg::IDX_W-1:0] pos;
    logic                      found;

    logic [1:0]                status_next;
    logic [sli_pkg::IDX_W-1:0] res_pos;

    logic                      m_valid_reg;
    logic [1:0]                m_status_reg;
    logic [9:0]                m_position_reg;
    logic [10:0]               m_entry_count_reg;
    logic                      m_is_empty_reg;
    logic                      m_is_full_reg;

    // cell row
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic signed [31:0] left_e;
        logic               left_f;
        logic signed [31:0] right_e;

        if (i == 0) begin : g_head
            assign left_e = value_reg;
            assign left_f = 1'b0;
        end else begin : g_body
            assign left_e = entry_w[i-1];
            assign left_f = flag_vec[i-1];
        end

        if (i == N - 1) begin : g_tail
            assign right_e = entry_w[i];
        end else begin : g_inner
            assign right_e = entry_w[i+1];
        end

        sli_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .value       (value_reg),
            .count       (count_reg),
            .cell_idx    (sli_pkg::IDX_W'(i)),
            .left_entry  (left_e),
            .left_flag   (left_f),
            .right_entry (right_e),
            .entry       (entry_w[i]),
            .flag        (flag_vec[i]),
            .first       (first_vec[i]),
            .eq          (eq_vec[i])
        );
    end

    sli_enc u_enc (
        .aclk      (aclk),
        .first_vec (first_vec),
        .eq_vec    (eq_vec),
        .pos       (pos),
        .found     (found)
    );

    assign list_full = (count_reg == sli_pkg::CNT_W'(N));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sli_pkg::ST_IDLE:  if (s_valid) state_next = sli_pkg::ST_CMP;
            sli_pkg::ST_CMP:   state_next = sli_pkg::ST_ENC1;
            sli_pkg::ST_ENC1:  state_next = sli_pkg::ST_ENC2;
            sli_pkg::ST_ENC2:  state_next = sli_pkg::ST_APPLY;
            sli_pkg::ST_APPLY: if (apply_go) state_next = sli_pkg::ST_IDLE;
            default:           state_next = sli_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready     = (state_reg == sli_pkg::ST_IDLE);
        apply_go    = (state_reg == sli_pkg::ST_APPLY) && (!m_valid_reg || m_ready);
        ctl.cmp_en  = (state_reg == sli_pkg::ST_CMP);
        ctl.ins_sel = (req_reg == sli_pkg::REQ_INSERT);
        ctl.do_ins  = apply_go && (req_reg == sli_pkg::REQ_INSERT) && !list_full;
        ctl.do_del  = apply_go && (req_reg == sli_pkg::REQ_DELETE) && found;
    end

    // result of the current request
    always_comb begin
        status_next = sli_pkg::STAT_OK;
        res_pos     = '0;
        count_next  = count_reg;
        case (req_reg)
            sli_pkg::REQ_INSERT: begin
                if (list_full) begin
                    status_next = sli_pkg::STAT_FULL;
                end else begin
                    res_pos    = pos;
                    count_next = count_reg + 1'b1;
                end
            end
            sli_pkg::REQ_DELETE: begin
                if (found) begin
                    res_pos    = pos;
                    count_next = count_reg - 1'b1;
                end else begin
                    status_next = sli_pkg::STAT_NOTFOUND;
                end
            end
            sli_pkg::REQ_LOOKUP: begin
                if (found) begin
                    res_pos = pos;
                end else begin
                    status_next = sli_pkg::STAT_NOTFOUND;
                end
            end
            default: begin
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sli_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (apply_go) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg   <= s_req_type;
            value_reg <= s_value;
        end
        if (apply_go) begin
            m_status_reg      <= status_next;
            m_position_reg    <= 10'(res_pos);
            m_entry_count_reg <= 11'(count_next);
            m_is_empty_reg    <= (count_next == '0);
            m_is_full_reg     <= (count_next == sli_pkg::CNT_W'(N));
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_position    = m_position_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_is_empty    = m_is_empty_reg;
    assign m_is_full     = m_is_full_reg;

    `SLI_ASSERT_ALWAYS(a_count_range, count_reg <= sli_pkg::CNT_W'(N),
        "stored count above capacity")
    `SLI_ASSERT_SAME(a_boundary_onehot, state_reg == sli_pkg::ST_ENC1, $onehot0(first_vec),
        "more than one boundary cell in the row")
    `SLI_ASSERT_NEXT(a_insert_count, ctl.do_ins,
        count_reg == sli_pkg::CNT_W'($past(count_reg) + 1'b1),
        "insert did not raise the count by one")
    `SLI_ASSERT_NEXT(a_delete_count, ctl.do_del,
        count_reg == sli_pkg::CNT_W'($past(count_reg) - 1'b1),
        "delete did not lower the count by one")

endmodule

`default_nettype wire
